// File: design/slsi_pkg.sv
// Shared widths, request codes and record types for the sorted score list.
package slsi_pkg;

   // Number of cells in the list.
   localparam int CAPACITY = 256;

   // Field widths fixed by the request and response formats.
   localparam int KIND_W  = 2;
   localparam int MOVE_W  = 15;
   localparam int SCORE_W = 16;
   localparam int DEPTH_W = 8;
   localparam int BOUND_W = 16;
   localparam int NODES_W = 64;
   localparam int INDEX_W = 8;
   localparam int KEEP_W  = 9;
   localparam int FILL_W  = 9;

   // Width of the held count, and a width that holds any index or count.
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > KEEP_W) ? CNT_W : KEEP_W;

   // Read-out tree: cells are gathered in groups, then groups are merged.
   localparam int GROUP_SIZE  = 16;
   localparam int GROUP_COUNT = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

   // Request kinds.
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

   // One scored record as held in a cell.
   typedef struct packed {
      logic        [MOVE_W-1:0]  move;
      logic signed [SCORE_W-1:0] score;
      logic        [DEPTH_W-1:0] depth;
      logic signed [BOUND_W-1:0] lower;
      logic signed [BOUND_W-1:0] upper;
      logic        [NODES_W-1:0] nodes;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Commands from the control logic to the cell chain.
   typedef struct packed {
      logic insert;
      logic clear;
   } chain_ctl_type;

endpackage

// File: design/slsi_req_if.sv
// Request channel: valid/ready handshake carrying one list operation.
interface slsi_req_if;
   import slsi_pkg::*;

   logic                      valid;
   logic                      ready;
   logic        [KIND_W-1:0]  kind;
   logic        [MOVE_W-1:0]  new_move;
   logic signed [SCORE_W-1:0] new_score;
   logic        [DEPTH_W-1:0] new_ply;
   logic signed [BOUND_W-1:0] new_lower;
   logic signed [BOUND_W-1:0] new_upper;
   logic        [NODES_W-1:0] new_nodes;
   logic        [INDEX_W-1:0] read_index;

   modport source (
      output valid, kind, new_move, new_score, new_ply, new_lower, new_upper,
             new_nodes, read_index,
      input  ready
   );

   modport sink (
      input  valid, kind, new_move, new_score, new_ply, new_lower, new_upper,
             new_nodes, read_index,
      output ready
   );
endinterface

// File: design/slsi_rsp_if.sv
// Response channel: valid/ready handshake carrying the reported entry and list status.
interface slsi_rsp_if;
   import slsi_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      out_valid;
   logic        [MOVE_W-1:0]  out_move;
   logic signed [SCORE_W-1:0] out_score;
   logic        [DEPTH_W-1:0] out_depth;
   logic signed [BOUND_W-1:0] out_lower;
   logic signed [BOUND_W-1:0] out_upper;
   logic        [NODES_W-1:0] out_nodes;
   logic        [FILL_W-1:0]  fill_level;
   logic                      cut_valid;
   logic signed [SCORE_W-1:0] cut_score;

   modport source (
      output valid, out_valid, out_move, out_score, out_depth, out_lower, out_upper,
             out_nodes, fill_level, cut_valid, cut_score,
      input  ready
   );

   modport sink (
      input  valid, out_valid, out_move, out_score, out_depth, out_lower, out_upper,
             out_nodes, fill_level, cut_valid, cut_score,
      output ready
   );
endinterface

// File: design/slsi_cell.sv
// One list cell: holds a record and keeps, takes the new record, or takes its upper neighbor.
module slsi_cell (
   input  logic                clock,
   input  logic                shift_en,
   input  logic                occupied,
   input  logic                above_ge,
   input  slsi_pkg::entry_type above_entry,
   input  slsi_pkg::entry_type new_entry,
   output slsi_pkg::entry_type entry_ff,
   output logic                ge
);
   import slsi_pkg::*;

   entry_type entry_in;

   // This cell stays put when it holds a record scoring at least the new one.
   assign ge = occupied && (entry_ff.score >= new_entry.score);

   // The first cell that does not stay takes the new record; cells below it shift down.
   always_comb begin
      entry_in = entry_ff;
      if (shift_en && !ge) begin
         if (above_ge) begin
            entry_in = new_entry;
         end else begin
            entry_in = above_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// File: design/slsi_chain.sv
// Row of list cells with the held count; inserts by parallel compare and shift.
module slsi_chain (
   input  logic                                         clock,
   input  logic                                         reset,
   input  slsi_pkg::chain_ctl_type                      ctl,
   input  slsi_pkg::entry_type                          new_entry,
   output slsi_pkg::entry_type [slsi_pkg::CAPACITY-1:0] entries,
   output logic [slsi_pkg::CNT_W-1:0]                   held_ff
);
   import slsi_pkg::*;

   logic [CAPACITY-1:0]      occupied;
   logic [CAPACITY-1:0]      ge;
   logic [CAPACITY-1:0]      above_ge;
   entry_type [CAPACITY-1:0] above_entry;
   logic                     shift_en;
   logic [CNT_W-1:0]         held_in;

   // Wire each cell to its upper neighbor; the top cell sees the new record.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign occupied[i] = held_ff > CNT_W'(i);

      if (i == 0) begin : g_top
         assign above_ge[i]    = 1'b1;
         assign above_entry[i] = new_entry;
      end else begin : g_rest
         assign above_ge[i]    = ge[i-1];
         assign above_entry[i] = entries[i-1];
      end

      slsi_cell u_cell (
         .clock       (clock),
         .shift_en    (shift_en),
         .occupied    (occupied[i]),
         .above_ge    (above_ge[i]),
         .above_entry (above_entry[i]),
         .new_entry   (new_entry),
         .entry_ff    (entries[i]),
         .ge          (ge[i])
      );
   end

   // A full list whose last entry ranks at or above the new record drops the new record.
   assign shift_en = ctl.insert && !ge[CAPACITY-1];

   // Held count follows inserts and clears, saturating at the capacity.
   always_comb begin
      held_in = held_ff;
      if (ctl.clear) begin
         held_in = '0;
      end else if (shift_en && (held_ff != CNT_W'(CAPACITY))) begin
         held_in = held_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else begin
         held_ff <= held_in;
      end
   end

endmodule

// File: design/slsi_pick.sv
// Two-stage registered selection tree that reads one cell's record and another cell's score.
module slsi_pick (
   input  logic                                         clock,
   input  slsi_pkg::entry_type [slsi_pkg::CAPACITY-1:0] entries,
   input  logic [slsi_pkg::CMP_W-1:0]                   read_sel,
   input  logic [slsi_pkg::CMP_W-1:0]                   cut_sel,
   output slsi_pkg::entry_type                          pick_entry_ff,
   output logic signed [slsi_pkg::SCORE_W-1:0]          pick_cut_ff
);
   import slsi_pkg::*;

   logic [ENTRY_W-1:0] masked     [GROUP_COUNT][GROUP_SIZE];
   logic [SCORE_W-1:0] cut_masked [GROUP_COUNT][GROUP_SIZE];
   logic [ENTRY_W-1:0] group_in     [GROUP_COUNT];
   logic [ENTRY_W-1:0] group_ff     [GROUP_COUNT];
   logic [SCORE_W-1:0] cut_group_in [GROUP_COUNT];
   logic [SCORE_W-1:0] cut_group_ff [GROUP_COUNT];
   logic [ENTRY_W-1:0] merge_in;
   logic [SCORE_W-1:0] cut_merge_in;

   // Each cell passes its record only when its position is the one selected.
   for (genvar g = 0; g < GROUP_COUNT; g++) begin : g_group
      for (genvar j = 0; j < GROUP_SIZE; j++) begin : g_slot
         localparam int K = g * GROUP_SIZE + j;
         if (K < CAPACITY) begin : g_used
            assign masked[g][j]     = (read_sel == CMP_W'(K)) ? entries[K] : '0;
            assign cut_masked[g][j] = (cut_sel == CMP_W'(K)) ? entries[K].score : '0;
         end else begin : g_pad
            assign masked[g][j]     = '0;
            assign cut_masked[g][j] = '0;
         end
      end
   end

   // First stage: combine the cells of each group.
   always_comb begin
      for (int g = 0; g < GROUP_COUNT; g++) begin
         group_in[g]     = '0;
         cut_group_in[g] = '0;
         for (int j = 0; j < GROUP_SIZE; j++) begin
            group_in[g]     = group_in[g] | masked[g][j];
            cut_group_in[g] = cut_group_in[g] | cut_masked[g][j];
         end
      end
   end

   always_ff @(posedge clock) begin
      group_ff     <= group_in;
      cut_group_ff <= cut_group_in;
   end

   // Second stage: combine the groups.
   always_comb begin
      merge_in     = '0;
      cut_merge_in = '0;
      for (int g = 0; g < GROUP_COUNT; g++) begin
         merge_in     = merge_in | group_ff[g];
         cut_merge_in = cut_merge_in | cut_group_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      pick_entry_ff <= entry_type'(merge_in);
      pick_cut_ff   <= cut_merge_in;
   end

endmodule

// File: design/sorted_score_list_insert.sv
// Sorted score list: a row of cells holding scored records in descending score order.
// An accepted request takes one cell update at the accept edge: an insert compares the new
// score against every cell at once and shifts the lower part of the list down by one, placing
// the new record below all entries of equal or higher score; a clear empties the list.
// The response (read entry or top entry, fill level, and the score at position keep_depth-1)
// is then gathered by a two-stage registered selection tree over the cells and lands in the
// output register in the load step once no older response waits. The next request is
// accepted while a finished response still waits to be taken. Record contents have no
// reset; only positions below the fill level are ever reported. keep_depth is written
// through csr_wr_en/csr_wr_data, by the user only while no request is in flight; unchecked.
module sorted_score_list_insert (
   input  logic                       clock,
   input  logic                       reset,
   slsi_req_if.sink                   req_if,
   slsi_rsp_if.source                 rsp_if,
   input  logic                       csr_wr_en,
   input  logic [slsi_pkg::KEEP_W-1:0] csr_wr_data
);
   import slsi_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_GATHER,
      ST_MERGE,
      ST_LOAD
   } state_type;

   state_type                state_ff;
   logic                     req_accept;
   logic                     out_free;
   logic [KEEP_W-1:0]        keep_depth_ff;
   logic [CMP_W-1:0]         sel_idx_ff;
   logic [CMP_W-1:0]         cut_idx;
   chain_ctl_type            chain_ctl;
   entry_type                new_entry;
   entry_type [CAPACITY-1:0] entries;
   logic [CNT_W-1:0]         held;
   entry_type                pick_entry;
   logic signed [SCORE_W-1:0] pick_cut;
   logic                     read_ok;
   logic                     cut_ok;

   logic                      rsp_valid_ff;
   logic                      out_valid_ff;
   entry_type                 out_entry_ff;
   logic [FILL_W-1:0]         fill_ff;
   logic                      cut_valid_ff;
   logic signed [SCORE_W-1:0] cut_score_ff;

   // Request handshake: one request in the cells and tree at a time.
   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_if.valid && req_if.ready;

   // Commands and record for the cell chain.
   assign chain_ctl.insert = req_accept && (req_if.kind == KIND_INSERT)
                             && (req_if.new_move != '0);
   assign chain_ctl.clear  = req_accept && (req_if.kind == KIND_CLEAR);

   assign new_entry.move  = req_if.new_move;
   assign new_entry.score = req_if.new_score;
   assign new_entry.depth = req_if.new_ply;
   assign new_entry.lower = req_if.new_lower;
   assign new_entry.upper = req_if.new_upper;
   assign new_entry.nodes = req_if.new_nodes;

   slsi_chain u_chain (
      .clock     (clock),
      .reset     (reset),
      .ctl       (chain_ctl),
      .new_entry (new_entry),
      .entries   (entries),
      .held_ff   (held)
   );

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         keep_depth_ff <= KEEP_W'(1);
      end else if (csr_wr_en) begin
         keep_depth_ff <= csr_wr_data;
      end
   end

   // Position reported: the read index for a read, the top entry otherwise.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         if (req_if.kind == KIND_READ) begin
            sel_idx_ff <= CMP_W'(req_if.read_index);
         end else begin
            sel_idx_ff <= '0;
         end
      end
   end

   assign cut_idx = CMP_W'(keep_depth_ff - KEEP_W'(1));

   slsi_pick u_pick (
      .clock         (clock),
      .entries       (entries),
      .read_sel      (sel_idx_ff),
      .cut_sel       (cut_idx),
      .pick_entry_ff (pick_entry),
      .pick_cut_ff   (pick_cut)
   );

   // Reported positions exist only below the fill level.
   assign read_ok = sel_idx_ff < CMP_W'(held);
   assign cut_ok  = (keep_depth_ff != '0) && (CMP_W'(keep_depth_ff) <= CMP_W'(held));

   assign out_free = !rsp_valid_ff || rsp_if.ready;

   // Sequencer and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  state_ff <= ST_GATHER;
               end
            end
            ST_GATHER: begin
               state_ff <= ST_MERGE;
            end
            ST_MERGE: begin
               state_ff <= ST_LOAD;
            end
            ST_LOAD: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  out_valid_ff <= read_ok;
                  out_entry_ff <= read_ok ? pick_entry : '0;
                  fill_ff      <= FILL_W'(held);
                  cut_valid_ff <= cut_ok;
                  cut_score_ff <= cut_ok ? pick_cut : '0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.out_valid  = out_valid_ff;
   assign rsp_if.out_move   = out_entry_ff.move;
   assign rsp_if.out_score  = out_entry_ff.score;
   assign rsp_if.out_depth  = out_entry_ff.depth;
   assign rsp_if.out_lower  = out_entry_ff.lower;
   assign rsp_if.out_upper  = out_entry_ff.upper;
   assign rsp_if.out_nodes  = out_entry_ff.nodes;
   assign rsp_if.fill_level = fill_ff;
   assign rsp_if.cut_valid  = cut_valid_ff;
   assign rsp_if.cut_score  = cut_score_ff;

   // A new response appears only when the sequencer loads it.
   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_LOAD))
      else $error("response raised outside the load step");

   // A clear request empties the list by the next cycle.
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_if.kind == KIND_CLEAR)) |=> (held == '0))
      else $error("clear request did not empty the list");

   // A reported entry always carries a real move.
   a_valid_entry_move: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && out_valid_ff) |-> (out_entry_ff.move != '0))
      else $error("reported entry has an empty move");

endmodule
